>>> sv/qemp_pkg.sv
// ---------------------------------------------------------------------------
// qemp_pkg: shared types for the quadratic extension power block
// Request and result structs, register indexes and sequencer states.
// ---------------------------------------------------------------------------
package qemp_pkg;

   typedef struct packed {
      logic [31:0] base_real;
      logic [31:0] base_root;
      logic [63:0] exponent;
   } req_type;

   typedef struct packed {
      logic [31:0] power_real;
      logic [31:0] power_root;
   } rsp_type;

   localparam logic [0:0] CSR_MODULUS  = 1'b0;
   localparam logic [0:0] CSR_RADICAND = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RED  = 4'b0010,
      S_MUL  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

endpackage

>>> sv/quadratic_ext_mod_pow.sv
// ---------------------------------------------------------------------------
// quadratic_ext_mod_pow: power in Z_m[sqrt(r)]
// Right-to-left square and multiply over one bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   Write modulus (index 0) and radicand (index 1) through csr_we/csr_index/
//   csr_wdata while the block is idle. Raise start with a request on req_data;
//   it is taken when busy is low. busy then stays high until the result is
//   ready; rsp_valid pulses for exactly one cycle, the first cycle with busy
//   low, with power_real/power_root on rsp_data. The receiver cannot stall:
//   take the result in that cycle. A new request may be given in that cycle.
// Sequence:
//   3 products reduce the base parts and the radicand, then each exponent bit
//   costs 5 products for the square, plus 5 more when the bit is set or a
//   single skip step when it is clear. All products run one after another
//   on the single shared modular multiplier.
//   A modulus of zero skips the arithmetic: the sequencer goes straight to
//   the done state, which raises rsp_valid with a zero result.
// Reset: modulus returns to 2, radicand to 0, the sequencer to idle.
// ---------------------------------------------------------------------------
module quadratic_ext_mod_pow import qemp_pkg::*; #(
   parameter int EXP_BITS = 64,
   parameter int MOD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int W  = MOD_BITS;
   localparam int EC = $clog2(EXP_BITS + 1);

   state_type     state_ff, state_in;
   logic [31:0]   modulus_ff, modulus_in;
   logic [31:0]   radicand_ff, radicand_in;
   logic          wait_ff, wait_in;
   logic          sq_ff, sq_in;
   logic [2:0]    step_ff, step_in;
   logic [EC-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [EXP_BITS-1:0] e_ff, e_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  bx_ff, bx_in, by_ff, by_in;
   logic [W-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic [W-1:0]  t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mm_start, mm_done;
   logic [W-1:0]  mm_a, mm_b, mm_res;
   logic [W-1:0]  one, p, q, re, ro;
   logic [W-1:0]  m_cur;

   // reduce a sum of two residues by one conditional subtract
   function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] md);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, md}) begin
         s = s - {1'b0, md};
      end
      return s[W-1:0];
   endfunction

   qemp_modmul #(.W(W)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .a      (mm_a),
      .b      (mm_b),
      .m      (m_ff),
      .done   (mm_done),
      .result (mm_res)
   );

   always_comb begin
      m_cur = modulus_ff[W-1:0];
      one   = (m_ff == W'(1)) ? '0 : W'(1);
      p     = sq_ff ? bx_ff : ax_ff;
      q     = sq_ff ? by_ff : ay_ff;
      re    = addm(t0_ff, mm_res, m_ff);
      ro    = addm(t1_ff, t2_ff, m_ff);
      // operand select for the current step
      mm_a = one;
      mm_b = bx_ff;
      if (state_ff == S_RED) begin
         case (step_ff)
            3'd0:    mm_b = bx_ff;
            3'd1:    mm_b = by_ff;
            3'd2:    mm_b = r_ff;
            default: mm_b = bx_ff;
         endcase
      end else begin
         case (step_ff)
            3'd0:    begin mm_a = p;     mm_b = bx_ff; end
            3'd1:    begin mm_a = p;     mm_b = by_ff; end
            3'd2:    begin mm_a = q;     mm_b = bx_ff; end
            3'd3:    begin mm_a = q;     mm_b = by_ff; end
            3'd4:    begin mm_a = t3_ff; mm_b = r_ff;  end
            default: begin mm_a = one;   mm_b = bx_ff; end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      radicand_in  = radicand_ff;
      wait_in      = wait_ff;
      sq_in        = sq_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      e_in  = e_ff;
      m_in  = m_ff;
      r_in  = r_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      rsp_in   = rsp_ff;
      mm_start = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:  modulus_in  = csr_wdata;
            CSR_RADICAND: radicand_in = csr_wdata;
            default:      modulus_in  = modulus_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // latch the request, masked to the modulus width
               m_in    = m_cur;
               r_in    = radicand_ff[W-1:0];
               bx_in   = req_data.base_real[W-1:0];
               by_in   = req_data.base_root[W-1:0];
               e_in    = req_data.exponent[EXP_BITS-1:0];
               ax_in   = (m_cur == W'(1)) ? '0 : W'(1);
               ay_in   = '0;
               cnt_in  = EC'(EXP_BITS);
               step_in = '0;
               sq_in   = 1'b0;
               wait_in = 1'b0;
               if (m_cur == '0) begin
                  ax_in    = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            if (!wait_ff) begin
               mm_start = 1'b1;
               wait_in  = 1'b1;
            end else if (mm_done) begin
               wait_in = 1'b0;
               step_in = step_ff + 3'd1;
               case (step_ff)
                  3'd0:    bx_in = mm_res;
                  3'd1:    by_in = mm_res;
                  default: begin
                     r_in     = mm_res;
                     step_in  = '0;
                     state_in = S_MUL;
                  end
               endcase
            end
         end
         S_MUL: begin
            if (!sq_ff && !e_ff[0]) begin
               // skip the multiply on a clear exponent bit
               sq_in = 1'b1;
            end else if (!wait_ff) begin
               mm_start = 1'b1;
               wait_in  = 1'b1;
            end else if (mm_done) begin
               wait_in = 1'b0;
               step_in = step_ff + 3'd1;
               case (step_ff)
                  3'd0: t0_in = mm_res;
                  3'd1: t1_in = mm_res;
                  3'd2: t2_in = mm_res;
                  3'd3: t3_in = mm_res;
                  default: begin
                     step_in = '0;
                     if (!sq_ff) begin
                        ax_in = re;
                        ay_in = ro;
                        sq_in = 1'b1;
                     end else begin
                        bx_in  = re;
                        by_in  = ro;
                        sq_in  = 1'b0;
                        e_in   = e_ff >> 1;
                        cnt_in = cnt_ff - 1'b1;
                        if (cnt_ff == EC'(1)) begin
                           state_in = S_DONE;
                        end
                     end
                  end
               endcase
            end
         end
         S_DONE: begin
            rsp_in.power_real = 32'(ax_ff);
            rsp_in.power_root = 32'(ay_ff);
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= 32'd2;
         radicand_ff  <= '0;
         wait_ff      <= 1'b0;
         sq_ff        <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         radicand_ff  <= radicand_in;
         wait_ff      <= wait_in;
         sq_ff        <= sq_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff   <= e_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
      bx_ff  <= bx_in;
      by_ff  <= by_in;
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      t3_ff  <= t3_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE)) else $error("result shown while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> wait_ff) else $error("product arrived unrequested");
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (ax_ff < m_ff && ay_ff < m_ff))
      else $error("accumulator not reduced");

endmodule

>>> sv/qemp_modmul.sv
// ---------------------------------------------------------------------------
// qemp_modmul: bit-serial modular multiplier
// Computes a*b mod m, one bit of b per cycle, most significant bit first.
// a must be below m; b may take any value.
// ---------------------------------------------------------------------------
module qemp_modmul import qemp_pkg::*; #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] result
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W:0]    dbl, dbl_red, sum;

   always_comb begin
      // double and add the multiplicand, reducing after each
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum     = dbl_red + (b_ff[W-1] ? {1'b0, a_ff} : '0);
      if (sum >= {1'b0, m_ff}) begin
         sum = sum - {1'b0, m_ff};
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         a_in    = a;
         b_in    = b;
         m_in    = m;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = sum[W-1:0];
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("modmul done while busy");
   a_acc_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (acc_ff < m_ff)) else $error("modmul result not reduced");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff) else $error("modmul failed to start");

endmodule

>>> tb/quadratic_ext_mod_pow_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadratic_ext_mod_pow_checker: result checker for the extension power block
// Tracks the register writes, predicts each power from an accepted request and
// compares every result pulse against the oldest prediction.
// ---------------------------------------------------------------------------
module quadratic_ext_mod_pow_checker import qemp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   logic [31:0] modulus_q;
   logic [31:0] radicand_q;
   rsp_type     powers_due[$];

   function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
      return (a * b) % m;
   endfunction

   // (p + q*sqrt(r)) * (s + t*sqrt(r)) mod m
   function automatic void ring_mul(input longint unsigned p, q, s, t, r, m,
                                    output longint unsigned re, ro);
      re = (mod_mul(p, s, m) + mod_mul(mod_mul(q, t, m), r, m)) % m;
      ro = (mod_mul(p, t, m) + mod_mul(q, s, m)) % m;
   endfunction

   function automatic rsp_type ring_power(req_type rq, logic [31:0] mv, logic [31:0] rv);
      longint unsigned m, r, bx, by, ax, ay, nx, ny;
      rsp_type res;
      m = mv;
      res = '0;
      if (m == 0) return res;
      r  = rv % m;
      bx = rq.base_real % m;
      by = rq.base_root % m;
      ax = 1 % m;
      ay = 0;
      for (int i = 0; i < 64; i++) begin
         if (rq.exponent[i]) begin
            ring_mul(ax, ay, bx, by, r, m, nx, ny);
            ax = nx;
            ay = ny;
         end
         ring_mul(bx, by, bx, by, r, m, nx, ny);
         bx = nx;
         by = ny;
      end
      res.power_real = ax[31:0];
      res.power_root = ay[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      int      errs;
      errs = 0;
      if (reset) begin
         modulus_q  <= 32'd2;
         radicand_q <= 32'd0;
         fail_count <= 0;
         checked    <= 0;
         powers_due.delete();
      end else begin
         // compare the pulse first, then queue any request taken at this edge
         if (rsp_valid) begin
            if (powers_due.size() == 0) begin
               $error("result (%0d, %0d) with no request outstanding",
                      rsp_data.power_real, rsp_data.power_root);
               errs++;
            end else begin
               due = powers_due.pop_front();
               checked <= checked + 1;
               if (rsp_data.power_real !== due.power_real) begin
                  $error("power_real expected %0d got %0d", due.power_real,
                         rsp_data.power_real);
                  errs++;
               end
               if (rsp_data.power_root !== due.power_root) begin
                  $error("power_root expected %0d got %0d", due.power_root,
                         rsp_data.power_root);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         if (start && !busy)
            powers_due.push_back(ring_power(req_data, modulus_q, radicand_q));
         if (csr_we) begin
            if (csr_index == CSR_MODULUS) modulus_q <= csr_wdata;
            else                          radicand_q <= csr_wdata;
         end
      end
   end

   assign pending = powers_due.size();

endmodule

>>> tb/quadratic_ext_mod_pow_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadratic_ext_mod_pow_tb: testbench top for the extension power block
// Drives directed and random requests across several modulus/radicand
// settings, with sender gaps, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module quadratic_ext_mod_pow_tb;
   import qemp_pkg::*;

   // worst item is about 643 products; allow plenty over that
   localparam longint CYCLE_LIMIT = 120_000_000;
   localparam int     RANDOM_PHASES = 6;
   localparam int     PHASE_ITEMS = 155;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          checked;
   longint      cycle_count;
   int          sent;
   int          gap_pct;

   quadratic_ext_mod_pow u_dut (
      .clock, .reset, .start, .busy, .req_data,
      .rsp_valid, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   quadratic_ext_mod_pow_checker u_checker (
      .clock, .reset, .start, .busy, .req_data,
      .rsp_valid, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending, .checked
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: drop the run if it stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // hold until every outstanding request has returned its result
   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // present one register write for one edge; the caller drops csr_we
   task automatic write_reg(logic [0:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_ring(logic [31:0] m, logic [31:0] r);
      start <= 1'b0;
      drain();
      @(posedge clock);
      write_reg(CSR_MODULUS, m);
      write_reg(CSR_RADICAND, r);
      csr_we <= 1'b0;
   endtask

   // present one request, possibly after a gap, and hold it until taken
   task automatic send(logic [31:0] x, logic [31:0] y, logic [63:0] n);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{base_real: x, base_root: y, exponent: n};
      do @(posedge clock); while (busy);
      sent++;
   endtask

   function automatic logic [31:0] pick_part(logic [31:0] m);
      case ($urandom_range(9))
         0:       return 32'd0;
         1:       return m - 32'd1;
         2:       return m;
         3:       return 32'hFFFF_FFFF;
         4:       return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] pick_exponent();
      case ($urandom_range(7))
         0:       return 64'(($urandom_range(3)));
         1:       return 64'hFFFF_FFFF_FFFF_FFFF;
         2:       return 64'(($urandom_range(1000)));
         3:       return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [31:0] m;
      logic [31:0] r;
      cycle_count = 0;
      sent        = 0;
      gap_pct     = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_MODULUS;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset ring (m = 2, r = 0) first
      send(32'd1, 32'd1, 64'd0);
      send(32'd3, 32'd5, 64'd7);
      // a small prime with a non-residue radicand
      set_ring(32'd13, 32'd2);
      send(32'd0, 32'd0, 64'd0);
      send(32'd0, 32'd0, 64'd5);
      send(32'd1, 32'd1, 64'd1);
      send(32'd13, 32'd26, 64'd3);
      send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(32'd2, 32'd3, 64'h8000_0000_0000_0000);
      // widest modulus and radicand at their tops
      set_ring(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(32'hFFFF_FFFE, 32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
      send(32'hFFFF_FFFF, 32'd1, 64'd2);
      send(32'd0, 32'hFFFF_FFFE, 64'd0);
      send(32'h8000_0000, 32'h7FFF_FFFF, 64'h5555_5555_5555_5555);
      // modulus of one: everything is zero, exponent zero too
      set_ring(32'd1, 32'd5);
      send(32'd7, 32'd9, 64'd0);
      send(32'd7, 32'd9, 64'd11);
      // modulus of zero: no arithmetic, result is zero
      set_ring(32'd0, 32'd3);
      send(32'd4, 32'd4, 64'd0);
      send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // radicand above the modulus
      set_ring(32'd3, 32'hFFFF_FFFF);
      send(32'd5, 32'd7, 64'd9);
      send(32'd2, 32'd2, 64'hAAAA_AAAA_AAAA_AAAA);

      // random phases: sender gaps 35 %, then 54 %, then none
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         gap_pct = (ph < 2) ? 35 : (ph < 4) ? 54 : 0;
         case (ph)
            0:       begin m = $urandom;               r = $urandom; end
            1:       begin m = $urandom_range(2, 1000); r = $urandom; end
            2:       begin m = 32'hFFFF_FFFF;          r = $urandom; end
            3:       begin m = $urandom | 32'h8000_0000; r = 32'hFFFF_FFFF; end
            4:       begin m = 32'hFFFF_FFFB;          r = 32'd0; end
            default: begin m = $urandom_range(2, 65535); r = $urandom_range(7); end
         endcase
         if (m < 2) m = 32'd2;
         set_ring(m, r);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // once per phase, let everything return before going on
            if (k == PHASE_ITEMS / 2) begin
               start <= 1'b0;
               drain();
            end
            send(pick_part(m), pick_part(m), pick_exponent());
         end
      end

      start <= 1'b0;
      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d requests over %0d ring settings, %0d results checked",
               sent, RANDOM_PHASES + 6, checked);
      $display("Covered moduli zero, one, small, large and all-ones; full exponents");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
sv/qemp_pkg.sv
sv/qemp_modmul.sv
sv/quadratic_ext_mod_pow.sv
tb/quadratic_ext_mod_pow_checker.sv
tb/quadratic_ext_mod_pow_tb.sv
